>>> rtl/ldfw_pkg.sv
// ----------------------------------------------------------------------------
// ldfw_pkg
// Types, constants and the digit step shared by the decimal field writer.
// ----------------------------------------------------------------------------
package ldfw_pkg;

  // Command bases and character codes
  localparam logic [7:0] CMD_ROW1_BASE = 8'h7F;
  localparam logic [7:0] CMD_ROW2_BASE = 8'hBF;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_ERR     = 8'h65;

  // Display geometry
  localparam logic [7:0] ROW_FIRST = 8'd1;
  localparam logic [7:0] ROW_LAST  = 8'd2;
  localparam logic [7:0] COL_FIRST = 8'd1;
  localparam logic [7:0] COL_LAST  = 8'd16;

  // Decimal places handled, most significant first
  localparam int unsigned NUM_DIGITS = 5;
  localparam logic [3:0]  MAX_COUNT  = 4'd5;
  localparam logic [16:0] PLACE_POW [NUM_DIGITS] = '{
    17'd10000, 17'd1000, 17'd100, 17'd10, 17'd1
  };

  // Default depth of the job queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  // Input item
  typedef struct packed {
    logic [7:0]  row;
    logic [7:0]  column;
    logic [15:0] value;
    logic [3:0]  digit_count;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } out_item_t;

  // Stage of the conversion pipe
  typedef struct packed {
    logic [7:0]                 cmd;
    logic                       err;
    logic [2:0]                 cnt;
    logic [15:0]                rem;
    logic [NUM_DIGITS-1:0][3:0] digits;
  } pipe_t;

  // Job handed from front to back
  typedef struct packed {
    logic [7:0]                 cmd;
    logic                       err;
    logic [2:0]                 cnt;
    logic [NUM_DIGITS-1:0][3:0] digits;
  } job_t;

  // One decimal digit and what is left below it
  typedef struct packed {
    logic [3:0]  digit;
    logic [15:0] rem;
  } dstep_t;

  // Peel one digit off r at place pw by a compare ladder
  function automatic dstep_t digit_step(input logic [15:0] r, input logic [16:0] pw);
    dstep_t     res;
    logic [16:0] sub;
    res.digit = 4'd0;
    for (int d = 1; d <= 9; d++) begin
      if ({1'b0, r} >= 17'(17'(d) * pw)) begin
        res.digit = 4'(d);
      end
    end
    sub     = 17'({13'd0, res.digit} * pw);
    res.rem = 16'({1'b0, r} - sub);
    return res;
  endfunction

endpackage

>>> rtl/ldfw_front.sv
// ----------------------------------------------------------------------------
// ldfw_front
// Accepts items, builds the cursor command and extracts five decimal digits,
// one digit per pipe stage.
// ----------------------------------------------------------------------------
module ldfw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ldfw_pkg::in_item_t in_data,
  output logic             push_valid,
  input  logic             push_ready,
  output ldfw_pkg::job_t   push_job
);
  import ldfw_pkg::*;

  localparam int unsigned STAGES = NUM_DIGITS + 1;

  pipe_t                stage_r   [STAGES];
  logic  [STAGES-1:0]   valid_r;
  logic  [STAGES-1:0]   valid_nxt;
  pipe_t                entry;
  logic                 adv;
  logic                 pos_ok;
  logic  [7:0]          row_eff;
  logic  [7:0]          col_eff;

  // Advance the whole pipe unless the tail is blocked by a full queue
  assign adv      = !valid_r[STAGES-1] || push_ready;
  assign in_stall = !adv;

  // Classify position and count
  always_comb begin
    pos_ok  = (in_data.row >= ROW_FIRST) && (in_data.row <= ROW_LAST) &&
              (in_data.column >= COL_FIRST) && (in_data.column <= COL_LAST);
    row_eff = pos_ok ? in_data.row : ROW_FIRST;
    col_eff = pos_ok ? in_data.column : COL_FIRST;
    entry        = '0;
    entry.cmd    = ((row_eff == ROW_FIRST) ? CMD_ROW1_BASE : CMD_ROW2_BASE) + col_eff;
    entry.err    = in_data.digit_count > MAX_COUNT;
    entry.cnt    = entry.err ? 3'd0 : in_data.digit_count[2:0];
    entry.rem    = in_data.value;
  end

  // Shift valid bits
  always_comb begin
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = {valid_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the head stage
  always_ff @(posedge clk) begin
    if (adv) begin
      stage_r[0] <= entry;
    end
  end

  // One digit per stage, most significant place first
  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
    dstep_t step;
    pipe_t  nxt;
    always_comb begin
      step   = digit_step(stage_r[k].rem, PLACE_POW[k]);
      nxt    = stage_r[k];
      nxt.rem = step.rem;
      nxt.digits[k] = step.digit;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        stage_r[k+1] <= nxt;
      end
    end
  end

  // Hand the finished job to the queue
  assign push_valid      = valid_r[STAGES-1];
  assign push_job.cmd    = stage_r[STAGES-1].cmd;
  assign push_job.err    = stage_r[STAGES-1].err;
  assign push_job.cnt    = stage_r[STAGES-1].cnt;
  assign push_job.digits = stage_r[STAGES-1].digits;

endmodule

>>> rtl/ldfw_queue.sv
// ----------------------------------------------------------------------------
// ldfw_queue
// Small job queue that lets front and back stall independently.
// ----------------------------------------------------------------------------
module ldfw_queue #(
  parameter int unsigned DEPTH = ldfw_pkg::Q_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  ldfw_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop,
  output ldfw_pkg::job_t pop_job
);
  import ldfw_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_job    = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the job
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> rtl/ldfw_back.sv
// ----------------------------------------------------------------------------
// ldfw_back
// Walks each job byte by byte: cursor command, then digits or the error mark.
// ----------------------------------------------------------------------------
module ldfw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  ldfw_pkg::job_t      job,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ldfw_pkg::out_item_t out_data
);
  import ldfw_pkg::*;

  logic [2:0] pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r;
  out_item_t  byte_nxt;
  logic       load;
  logic [2:0] n_bytes;
  logic [2:0] dig_idx;

  // Refill the output register when empty or being taken
  assign load = !out_valid_r || !out_stall;

  // Pick the byte for the current position
  always_comb begin
    n_bytes  = job.err ? 3'd2 : 3'(job.cnt + 3'd1);
    dig_idx  = 3'(3'd4 + pos_r - job.cnt);
    byte_nxt = '0;
    if (pos_r == 3'd0) begin
      byte_nxt.out_byte = job.cmd;
      byte_nxt.is_data  = 1'b0;
    end else if (job.err) begin
      byte_nxt.out_byte = ASCII_ERR;
      byte_nxt.is_data  = 1'b1;
    end else begin
      byte_nxt.out_byte = ASCII_ZERO + {4'd0, job.digits[dig_idx]};
      byte_nxt.is_data  = 1'b1;
    end
    byte_nxt.last = pos_r == 3'(n_bytes - 3'd1);
  end

  // Step position, drop the job after its last byte
  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    job_pop       = 1'b0;
    if (load) begin
      out_valid_nxt = job_valid;
      if (job_valid) begin
        if (byte_nxt.last) begin
          pos_nxt = 3'd0;
          job_pop = 1'b1;
        end else begin
          pos_nxt = pos_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the byte while stalled
  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      out_r <= byte_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/lcd_decimal_field_writer.sv
// An accepted item's cursor command passes the front pipe and job queue to out_*.
// Throughput: one byte per cycle while out_stall is low; an item takes 1..6 bytes;
//   the single output byte register sets this figure, and items follow seamlessly.
// Reset (rst_n low, synchronous) empties the conversion pipe, the job queue and
//   the output register; payload registers keep their contents.
// ----------------------------------------------------------------------------
// lcd_decimal_field_writer
// Turns a row, column and 16-bit value into a cursor command and ASCII digits or an error mark.
// ----------------------------------------------------------------------------
module lcd_decimal_field_writer #(
  parameter int unsigned QUEUE_DEPTH = ldfw_pkg::Q_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ldfw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ldfw_pkg::out_item_t out_data
);
  import ldfw_pkg::*;

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic job_valid;
  logic job_pop;
  job_t job;

  ldfw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  ldfw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (job_valid),
    .pop        (job_pop),
    .pop_job    (job)
  );

  ldfw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/ldfw_checker.sv
// ----------------------------------------------------------------------------
// ldfw_checker
// Port-level checks on the byte stream of the decimal field writer.
// ----------------------------------------------------------------------------
module ldfw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input ldfw_pkg::out_item_t out_data
);
  import ldfw_pkg::*;

  logic out_acc;
  logic expect_cmd_r;

  assign out_acc = out_valid && !out_stall;

  // Track whether the next byte opens a new item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_cmd_r <= 1'b1;
    end else if (out_acc) begin
      expect_cmd_r <= out_data.last;
    end
  end

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Each item opens with a command and continues with data
  a_cmd_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (out_data.is_data == !expect_cmd_r))
    else $error("command/data order broken");

  // Commands address row 1 or row 2, columns 1..16
  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_data.is_data |->
      ((out_data.out_byte >= 8'h80) && (out_data.out_byte <= 8'h8F)) ||
      ((out_data.out_byte >= 8'hC0) && (out_data.out_byte <= 8'hCF)))
    else $error("cursor command out of range");

  // Non-final data bytes are decimal digits
  a_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_data.is_data && !out_data.last |->
      (out_data.out_byte >= ASCII_ZERO) && (out_data.out_byte <= 8'h39))
    else $error("data byte is not a digit");

endmodule

bind lcd_decimal_field_writer ldfw_checker u_ldfw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
